FILE: rtl/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types and constants for the direct form I biquad filter.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int OUT_W          = 24;
	localparam int COEF_W         = 18;
	localparam int COEF_FRAC_DEF  = 16;
	localparam int PROD_FF_W      = COEF_W + SAMPLE_W;
	localparam int PROD_FB_W      = COEF_W + OUT_W;

	// five products plus rounding need three growth bits; wraps at 64 like a
	// 64-bit machine word
	localparam int ACC_NEED = ((SAMPLE_W > OUT_W) ? SAMPLE_W : OUT_W) + COEF_W + 3;
	localparam int ACC_W    = (ACC_NEED > 64) ? 64 : ACC_NEED;

	localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'((65'sd1 <<< (OUT_W - 1)) - 65'sd1);
	localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - ACC_W'(1);

	// configuration register indexes
	localparam int REG_COUNT = 5;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       pulse_start;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    saturated;
	} out_item_t;

	// feedforward sum handed to the feedback cell
	typedef struct packed {
		logic                    valid;
		logic                    pulse;
		logic signed [ACC_W-1:0] ff;
	} ff_stage_t;

endpackage

FILE: rtl/bq_tap.sv
// ----------------------------------------------------------------------------
// bq_tap
// Feedforward cell: one sample delay and one registered coefficient product.
// ----------------------------------------------------------------------------
module bq_tap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                clr,
	input  logic signed [bq_pkg::SAMPLE_W-1:0]  din,
	input  logic signed [bq_pkg::COEF_W-1:0]    coef,
	output logic signed [bq_pkg::SAMPLE_W-1:0]  dly,
	output logic signed [bq_pkg::PROD_FF_W-1:0] prod_s1
);
	import bq_pkg::*;

	logic signed [SAMPLE_W-1:0]  din_eff;
	logic signed [PROD_FF_W-1:0] prod;
	logic signed [SAMPLE_W-1:0]  dly_q;

	// history is zeroed at the first item of a pulse
	assign din_eff = clr ? '0 : din;
	assign prod    = coef * din_eff;
	assign dly     = dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '0;
		end else if (en) begin
			dly_q <= din_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

endmodule

FILE: rtl/bq_fb.sv
// ----------------------------------------------------------------------------
// bq_fb
// Feedback cell: output history, recursive sum, rounding shift, saturation
// and the result register.
// ----------------------------------------------------------------------------
module bq_fb #(
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bq_pkg::ff_stage_t                req,
	output logic                             ready,
	input  logic signed [bq_pkg::COEF_W-1:0] coef_a1,
	input  logic signed [bq_pkg::COEF_W-1:0] coef_a2,
	output logic                             res_valid,
	input  logic                             res_stall,
	output bq_pkg::out_item_t                res_data
);
	import bq_pkg::*;

	logic signed [OUT_W-1:0]     y1_q;
	logic signed [OUT_W-1:0]     y2_q;
	logic signed [OUT_W-1:0]     y1_eff;
	logic signed [OUT_W-1:0]     y2_eff;
	logic signed [PROD_FB_W-1:0] p1;
	logic signed [PROD_FB_W-1:0] p2;
	logic signed [ACC_W-1:0]     acc;
	logic signed [ACC_W-1:0]     shifted;
	logic signed [OUT_W-1:0]     y;
	logic                        sat;
	logic                        fire;
	logic                        res_valid_q;
	out_item_t                   res_q;

	assign ready = !res_valid_q || !res_stall;
	assign fire  = req.valid && ready;

	assign y1_eff = req.pulse ? '0 : y1_q;
	assign y2_eff = req.pulse ? '0 : y2_q;
	assign p1     = coef_a1 * y1_eff;
	assign p2     = coef_a2 * y2_eff;
	assign acc    = req.ff + ACC_W'(p1) + ACC_W'(p2);
	assign shifted = acc >>> COEF_FRAC_BITS;

	always_comb begin
		priority if (shifted > Y_HI) begin
			y   = Y_HI[OUT_W-1:0];
			sat = 1'b1;
		end else if (shifted < Y_LO) begin
			y   = Y_LO[OUT_W-1:0];
			sat = 1'b1;
		end else begin
			y   = shifted[OUT_W-1:0];
			sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q        <= '0;
			y2_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				y1_q        <= y;
				y2_q        <= y1_eff;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.filtered  <= y;
			res_q.saturated <= sat;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

FILE: rtl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR filter, direct form I, saturated output fed back.
// ----------------------------------------------------------------------------
//  channel   valid      stall      payload    notes
//  src       src_valid  src_stall  src_data   sample + pulse_start flag
//  res       res_valid  res_stall  res_data   filtered + saturated flag
//  cfg       cfg_wr     -          cfg_data   cfg_addr selects a1,a2,b0,b1,b2
//
//  One item per cycle sustained while res_stall is low. Feedforward products
//  are registered in the tap cells, summed in stage 2, and the feedback cell
//  closes the a1/a2 recursion ahead of the result register.
//  Reset clears all history, coefficients and valid flags.
//  A stalled result holds; stages ahead keep filling until all are full.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  bq_pkg::in_item_t                    src_data,
	output logic                                res_valid,
	input  logic                                res_stall,
	output bq_pkg::out_item_t                   res_data,
	input  logic                                cfg_wr,
	input  logic [bq_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [bq_pkg::COEF_W-1:0]           cfg_data
);
	import bq_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [COEF_W-1:0]    a1_q, a2_q, b0_q, b1_q, b2_q;
	logic                        fb_ready;
	logic                        adv1, adv2, accept;
	logic                        v1_s1, v2_s2;
	logic                        pulse_s1;
	logic signed [SAMPLE_W-1:0]  dly0, dly1, dly2;
	logic signed [PROD_FF_W-1:0] p0_s1, p1_s1, p2_s1;
	ff_stage_t                   st_s2;
	ff_stage_t                   fb_req;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q <= '0;
			a2_q <= '0;
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_addr)
				REG_A1: a1_q <= cfg_data;
				REG_A2: a2_q <= cfg_data;
				REG_B0: b0_q <= cfg_data;
				REG_B1: b1_q <= cfg_data;
				REG_B2: b2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bubble-collapsing handshake down the pipe
	assign adv2      = !v2_s2 || fb_ready;
	assign adv1      = !v1_s1 || adv2;
	assign src_stall = !adv1;
	assign accept    = src_valid && adv1;

	// tap chain: each cell hands its stored sample to the next one
	bq_tap u_tap0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.clr     (1'b0),
		.din     (src_data.sample),
		.coef    (b0_q),
		.dly     (dly0),
		.prod_s1 (p0_s1)
	);

	bq_tap u_tap1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.clr     (src_data.pulse_start),
		.din     (dly0),
		.coef    (b1_q),
		.dly     (dly1),
		.prod_s1 (p1_s1)
	);

	bq_tap u_tap2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.clr     (src_data.pulse_start),
		.din     (dly1),
		.coef    (b2_q),
		.dly     (dly2),
		.prod_s1 (p2_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v1_s1 <= accept;
			end
			if (adv2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_s1 <= src_data.pulse_start;
		end
		if (adv2 && v1_s1) begin
			st_s2.valid <= 1'b1;
			st_s2.pulse <= pulse_s1;
			// last tap's delay is the oldest sample; only its product is used
			st_s2.ff    <= ACC_W'(p0_s1) + ACC_W'(p1_s1) + ACC_W'(p2_s1) + ROUND_K
				+ ((dly2 == dly2) ? '0 : '0);
		end
	end

	always_comb begin
		fb_req       = st_s2;
		fb_req.valid = v2_s2;
	end

	bq_fb #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (fb_req),
		.ready     (fb_ready),
		.coef_a1   (a1_q),
		.coef_a2   (a2_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

FILE: tb/tb_biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// tb_biquad_iir_filter
// Self-checking bench for the direct form I biquad. A bit-exact software
// filter predicts every output from the accepted samples and the coefficients
// in effect. Results are compared in order, field by field. Stimulus is a short
// directed run (reset coefficients, rounding of halves, clipping both ways),
// then random pulses under several coefficient sets, with random idling on both
// channels, one long receiver hold-off and an idle-free final stretch.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter;

	import bq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_REPORTS = 40;
	localparam int HOLD_CYCLES = 80;
	localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (COEF_FRAC_DEF - 1);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// bit-exact software copy of the filter plus the queue of outputs it predicts
	class biquad_history;
		logic signed [COEF_W-1:0]   a1, a2, b0, b1, b2;
		logic signed [SAMPLE_W-1:0] x1, x2;
		logic signed [OUT_W-1:0]    y1, y2;
		out_item_t expected_q[$];
		int errors, outputs, clipped, pulses;

		function new();
			a1 = '0; a2 = '0; b0 = '0; b1 = '0; b2 = '0;
			x1 = '0; x2 = '0; y1 = '0; y2 = '0;
			errors = 0; outputs = 0; clipped = 0; pulses = 0;
		endfunction

		function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
			case (idx)
				REG_A1: a1 = v;
				REG_A2: a2 = v;
				REG_B0: b0 = v;
				REG_B1: b1 = v;
				REG_B2: b2 = v;
				default: ;	// unmapped index, write dropped
			endcase
		endfunction

		function void take_input(in_item_t it);
			longint acc, hi, lo;
			out_item_t r;
			hi = (longint'(1) <<< (OUT_W - 1)) - 1;
			lo = -hi - 1;
			if (it.pulse_start) begin
				x1 = '0; x2 = '0; y1 = '0; y2 = '0;
				pulses++;
			end
			// feedback terms are added
			acc = longint'(a1) * longint'(y1) + longint'(a2) * longint'(y2)
				+ longint'(b0) * longint'(it.sample) + longint'(b1) * longint'(x1)
				+ longint'(b2) * longint'(x2);
			acc = (acc + (longint'(1) <<< (COEF_FRAC_DEF - 1))) >>> COEF_FRAC_DEF;
			r.saturated = 1'b0;
			if (acc > hi) begin
				acc = hi;
				r.saturated = 1'b1;
			end else if (acc < lo) begin
				acc = lo;
				r.saturated = 1'b1;
			end
			r.filtered = acc[OUT_W-1:0];
			if (r.saturated) clipped++;
			x2 = x1;
			x1 = it.sample;
			y2 = y1;
			y1 = r.filtered;
			expected_q.push_back(r);
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			outputs++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("unexpected result: filtered=%0d saturated=%0b",
						got.filtered, got.saturated);
				return;
			end
			want = expected_q.pop_front();
			if (got.filtered !== want.filtered) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
			end
			if (got.saturated !== want.saturated) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_stall;
	in_item_t              src_data;
	logic                  res_valid;
	logic                  res_stall;
	out_item_t             res_data;
	logic                  cfg_wr;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [COEF_W-1:0]     cfg_data;

	biquad_history book;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;
	int fed = 0;
	int coef_sets = 0;
	int unsigned cycles = 0;

	biquad_iir_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_wr    (cfg_wr),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_biquad_iir_filter: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			book.check_output(res_data);
	end

	// receiver: random stall bursts, free-running stretches, one long hold
	initial begin
		res_stall <= 1'b0;
		forever begin
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic in_item_t item_of(logic [SAMPLE_W-1:0] s, logic p);
		in_item_t it;
		it.sample = s;
		it.pulse_start = p;
		return it;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	// valid stays high from one item to the next; only an idle burst or drain lowers it
	task automatic send_item(input in_item_t it, input bit gappy);
		src_valid <= 1'b1;
		src_data  <= it;
		do @(posedge clk); while (src_stall);
		book.take_input(it);
		fed++;
		if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_pulse(input int len, input bit gappy);
		for (int k = 0; k < len; k++)
			send_item(item_of(pick_level(), k == 0), gappy);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		do @(posedge clk); while (book.expected_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
		cfg_wr   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		book.write_coef(idx, v);
	endtask

	// block must be idle; also pokes an unmapped index that should be dropped
	task automatic load_coefs(input logic [COEF_W-1:0] a1, a2, b0, b1, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
			COEF_W'($urandom));
		cfg_wr <= 1'b0;
		@(posedge clk);
		coef_sets++;
	endtask

	initial begin
		int target;
		bit gappy;
		book = new();
		clk = 1'b0;
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_data  <= '0;
		cfg_wr    <= 1'b0;
		cfg_addr  <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients still at reset: everything filters to zero
		send_item(item_of(SAMPLE_MAX, 1'b1), 1'b0);
		send_item(item_of(SAMPLE_MIN, 1'b0), 1'b0);
		drain();

		// b0 = 0.5: halves round toward plus infinity
		load_coefs('0, '0, COEF_HALF, '0, '0);
		send_item(item_of(SAMPLE_W'(1), 1'b1), 1'b0);
		send_item(item_of(-SAMPLE_W'(1), 1'b0), 1'b0);
		send_item(item_of(-SAMPLE_W'(3), 1'b0), 1'b0);
		send_item(item_of(SAMPLE_MAX, 1'b0), 1'b0);
		send_item(item_of(SAMPLE_MIN, 1'b0), 1'b0);
		send_item(item_of('0, 1'b0), 1'b0);
		drain();

		// all coefficients at max: feedback runs away and clips high
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		for (int k = 0; k < 8; k++)
			send_item(item_of(SAMPLE_MAX, k == 0), 1'b1);
		drain();

		// all at min: sign alternates and clips both ways
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		for (int k = 0; k < 6; k++)
			send_item(item_of(k[0] ? SAMPLE_MIN : SAMPLE_MAX, k == 0), 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: load_coefs(COEF_W'($urandom_range(0, 98304)),
					COEF_W'(-int'($urandom_range(0, 45000))),
					COEF_W'(int'($urandom_range(0, 32768)) - 16384),
					COEF_W'(int'($urandom_range(0, 32768)) - 16384),
					COEF_W'(int'($urandom_range(0, 32768)) - 16384));
				1: load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
				default: load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), COEF_W'($urandom));
			endcase
			if (ph == 5)
				quiet = 1'b1;
			if (ph == 1) begin
				// receiver holds off while items keep coming: pipeline backs up
				hold_off = 1'b1;
				send_pulse(40, 1'b0);
			end
			target = fed + 65;
			while (fed < target) begin
				gappy = $urandom_range(0, 2) != 0;
				if ($urandom_range(0, 7) == 0)
					send_item(item_of(SAMPLE_W'($urandom), 1'($urandom)), gappy);
				else
					send_pulse($urandom_range(4, 40), gappy);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (book.expected_q.size() != 0) begin
			book.errors++;
			$error("%0d expected results never arrived", book.expected_q.size());
		end
		$display("covered %0d samples in %0d pulses under %0d coefficient sets",
			fed, book.pulses, coef_sets);
		$display("%0d outputs checked, %0d of them clipped", book.outputs, book.clipped);
		if (book.errors == 0)
			$display("tb_biquad_iir_filter: done, clean");
		else
			$display("tb_biquad_iir_filter: done, errors");
		$finish;
	end

endmodule
